>>> hw/rtl/lbcl_pkg.sv
// Shared constants, types and state codes of the LED brightness current limiter.
package lbcl_pkg;

    localparam int MAX_LEDS = 1024;
    localparam int POS_W    = $clog2(MAX_LEDS);
    localparam int CNT_W    = POS_W + 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LEDS - 1);

    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int CH_IDX_W = $clog2(NUM_CH);
    localparam int SUM_W    = 20;
    localparam int BUDGET_W = 26;
    localparam int THR_W    = 9;
    localparam int MA_W     = 16;

    // Shared divider sizing
    localparam int DIV_W  = 38;
    localparam int DEN_W  = 20;
    localparam int DCNT_W = 6;
    localparam int NUM_W  = 29;

    localparam logic [DCNT_W-1:0] NB_BUDGET = DCNT_W'(NUM_W);
    localparam logic [DCNT_W-1:0] NB_THR    = DCNT_W'(THR_W);

    // Current estimate: x/3000 = (x>>3)/375, done as a multiply by ceil(2^34/375).
    // Exact for x>>3 below 2^25; anything from 65536*3000 up saturates.
    localparam int                MA_PROD_W = 51;
    localparam logic [25:0]       MA_RECIP  = 26'd45812985;
    localparam int                MA_SHIFT  = 34;
    localparam logic [DIV_W-1:0]  MA_SAT_AT = DIV_W'(196608000);

    localparam logic [BUDGET_W-1:0] BUDGET_MAX = '1;

    // Configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MA_PER_LED = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MA_MAX     = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BUDGET,
        ST_BUDGET_WAIT,
        ST_THR,
        ST_THR_WAIT,
        ST_SCALE,
        ST_LIMIT,
        ST_MUL_A,
        ST_MUL_B,
        ST_MA_DIV,
        ST_MA_WAIT,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DCNT_W-1:0] nbits;
        logic [DIV_W-1:0]  dividend;
        logic [DEN_W-1:0]  divisor;
    } div_req_t;

endpackage

>>> hw/rtl/lbcl_div.sv
// Shared restoring divider, one quotient bit per cycle, dividend left aligned.
module lbcl_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lbcl_pkg::div_req_t      req,
    output logic                    done,
    output logic [lbcl_pkg::DIV_W-1:0] quotient
);
    import lbcl_pkg::*;

    logic [DIV_W-1:0]  quot_reg, quot_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DEN_W:0] shifted;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb
    begin
        shifted = {rem_reg, quot_reg[DIV_W-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = shifted >= {1'b0, den_reg};
    end

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = req.nbits;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[DIV_W-2:0], ge};
            rem_next  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    // low bits hold the quotient; the bits above are the zero fill of the aligned dividend
    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> hw/rtl/lbcl_scale.sv
// Brightness scaling of one color channel.
module lbcl_scale (
    input  logic [lbcl_pkg::CH_W-1:0]  chan,
    input  logic [lbcl_pkg::CH_W-1:0]  bright,
    input  logic [lbcl_pkg::THR_W-1:0] thresh,
    output logic [lbcl_pkg::CH_W-1:0]  scaled
);
    import lbcl_pkg::*;

    logic [2*CH_W-1:0] prod;

    always_comb
    begin
        prod = {{CH_W{1'b0}}, chan} * {{CH_W{1'b0}}, bright};
        if (bright == '0)
            scaled = chan;
        else if (chan == '0)
            scaled = '0;
        else if ({1'b0, chan} <= thresh)
            scaled = CH_W'(1);
        else
            scaled = prod[2*CH_W-1:CH_W];
    end

endmodule

>>> hw/rtl/led_brightness_current_limiter.sv
// Top level of the LED brightness current limiter: registers, sequencer and frame state.
// A mid-frame pixel runs ST_SCALE per channel, ST_LIMIT, ST_PUT; input stalls until ST_IDLE.
// First pixel of a frame: the budget division first (skipped with zero ma_per_led), then the
// dim threshold when brightness is nonzero. Last pixel: the current estimate before ST_PUT.
// Both divisions share one restoring divider; output stalls hold the sequencer in ST_PUT.
// Reset (rst_n, async, low) clears sequencer, totals and out_valid; loads 0, 60, 2000.
module led_brightness_current_limiter (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            wr_en,
    input  logic [lbcl_pkg::REG_IDX_W-1:0]  wr_index,
    input  logic [15:0]                     wr_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      red,
    input  logic [7:0]                      green,
    input  logic [7:0]                      blue,
    input  logic                            last_pixel,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_red,
    output logic [7:0]                      out_green,
    output logic [7:0]                      out_blue,
    output logic                            was_limited,
    output logic                            frame_end,
    output logic [15:0]                     ma_used,
    output logic [10:0]                     num_limited
);
    import lbcl_pkg::*;

    // ---------------- configuration registers ----------------
    logic [CH_W-1:0] brightness_reg;
    logic [15:0]     ma_per_led_reg;
    logic [15:0]     ma_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= '0;
            ma_per_led_reg <= 16'd60;
            ma_max_reg     <= 16'd2000;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_BRIGHTNESS: brightness_reg <= (wr_data[7:0] == 8'hFF) ? '0 : wr_data[7:0];
                REG_MA_PER_LED: ma_per_led_reg <= wr_data;
                REG_MA_MAX:     ma_max_reg     <= wr_data;
                default:        ;   // unknown index, write dropped
            endcase
        end
    end

    // ---------------- state ----------------
    state_t state_reg, state_next;

    logic [CH_W-1:0]     pix_reg [NUM_CH];
    logic [CH_W-1:0]     scaled_reg [NUM_CH];
    logic                last_reg;
    logic [CH_IDX_W-1:0] ch_idx_reg;

    logic [CH_W-1:0]     frame_bright_reg;
    logic [BUDGET_W-1:0] budget_reg;
    logic [THR_W-1:0]    thr_reg;

    logic [SUM_W-1:0]    used_sum_reg;
    logic                limit_reg;
    logic [CNT_W-1:0]    lim_count_reg;
    logic [POS_W-1:0]    pos_reg;

    logic [CH_W-1:0]     res_pix_reg [NUM_CH];
    logic                res_limited_reg;
    logic [29:0]         mul_a_reg;
    logic [DIV_W-1:0]    mul_b_reg;
    logic [MA_PROD_W-1:0] recip_reg;
    logic [MA_W-1:0]     ma_reg;

    logic                out_valid_reg;
    logic [CH_W-1:0]     out_red_reg, out_green_reg, out_blue_reg;
    logic                out_limited_reg, out_end_reg;
    logic [MA_W-1:0]     out_ma_reg;
    logic [CNT_W-1:0]    out_count_reg;

    // ---------------- handshakes ----------------
    logic in_xfer;
    logic out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // ---------------- shared divider ----------------
    div_req_t          div_req;
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;

    lbcl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    // budget = (ma_max*7680 + 5) / (ma_per_led*10); 7680 = 8192 - 512
    logic [NUM_W-1:0] budget_num;
    logic [DEN_W-1:0] budget_den;
    logic             den_zero;

    assign budget_num = {ma_max_reg, 13'b0} - {4'b0, ma_max_reg, 9'b0} + NUM_W'(5);
    assign budget_den = {1'b0, ma_per_led_reg, 3'b0} + {3'b0, ma_per_led_reg, 1'b0};
    assign den_zero   = (ma_per_led_reg == '0);

    // ---------------- channel scaler, one channel per cycle ----------------
    logic [CH_W-1:0] scale_out;

    lbcl_scale u_scale (
        .chan   (pix_reg[ch_idx_reg]),
        .bright (frame_bright_reg),
        .thresh (thr_reg),
        .scaled (scale_out)
    );

    // ---------------- budget check ----------------
    logic [9:0]       sum3;
    logic [SUM_W:0]   trial;
    logic             over;
    logic             lim_now;
    logic             nonblack;
    logic [SUM_W-1:0] used_base;
    logic [SUM_W-1:0] used_new;
    logic [CNT_W-1:0] count_new;

    always_comb
    begin
        sum3      = {2'b0, scaled_reg[0]} + {2'b0, scaled_reg[1]} + {2'b0, scaled_reg[2]};
        trial     = {1'b0, used_sum_reg} + {11'b0, sum3};
        over      = {5'b0, trial} > budget_reg;
        lim_now   = limit_reg || over;
        nonblack  = (scaled_reg[0] != '0) || (scaled_reg[1] != '0) || (scaled_reg[2] != '0);
        used_base = lim_now ? used_sum_reg : trial[SUM_W-1:0];
        used_new  = (lim_now && nonblack) ? used_base + SUM_W'(3) : used_base;
        count_new = lim_now ? lim_count_reg + 1'b1 : lim_count_reg;
    end

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_xfer)
                    state_next = (pos_reg == '0) ? ST_BUDGET : ST_SCALE;
            ST_BUDGET:
                if (!den_zero)
                    state_next = ST_BUDGET_WAIT;
                else
                    state_next = (frame_bright_reg != '0) ? ST_THR : ST_SCALE;
            ST_BUDGET_WAIT:
                if (div_done)
                    state_next = (frame_bright_reg != '0) ? ST_THR : ST_SCALE;
            ST_THR:
                state_next = ST_THR_WAIT;
            ST_THR_WAIT:
                if (div_done)
                    state_next = ST_SCALE;
            ST_SCALE:
                if (ch_idx_reg == CH_IDX_W'(NUM_CH - 1))
                    state_next = ST_LIMIT;
            ST_LIMIT:
                state_next = last_reg ? ST_MUL_A : ST_PUT;
            ST_MUL_A:
                state_next = ST_MUL_B;
            ST_MUL_B:
                state_next = ST_MA_DIV;
            ST_MA_DIV:
                state_next = ST_MA_WAIT;
            ST_MA_WAIT:
                state_next = ST_PUT;
            ST_PUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: divider requests ----------------
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.nbits    = NB_BUDGET;
        div_req.dividend = {budget_num, {(DIV_W - NUM_W){1'b0}}};
        div_req.divisor  = budget_den;
        unique case (state_reg)
            ST_BUDGET:
                div_req.start = !den_zero;
            ST_THR:
            begin
                div_req.start    = 1'b1;
                div_req.nbits    = NB_THR;
                div_req.dividend = {THR_W'(256), {(DIV_W - THR_W){1'b0}}};
                div_req.divisor  = {{(DEN_W - CH_W){1'b0}}, frame_bright_reg};
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------- frame state and control counters ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_idx_reg       <= '0;
            frame_bright_reg <= '0;
            used_sum_reg     <= '0;
            limit_reg        <= 1'b0;
            lim_count_reg    <= '0;
            pos_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_IDLE)
                ch_idx_reg <= '0;
            else if (state_reg == ST_SCALE)
                ch_idx_reg <= ch_idx_reg + 1'b1;

            // brightness holds for the whole frame
            if (in_xfer && (pos_reg == '0))
                frame_bright_reg <= brightness_reg;

            if (state_reg == ST_LIMIT)
            begin
                used_sum_reg  <= used_new;
                limit_reg     <= lim_now;
                lim_count_reg <= count_new;
            end

            if ((state_reg == ST_PUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    used_sum_reg  <= '0;
                    limit_reg     <= 1'b0;
                    lim_count_reg <= '0;
                    pos_reg       <= '0;
                end
                else
                    pos_reg <= pos_reg + 1'b1;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pix_reg[0] <= red;
            pix_reg[1] <= green;
            pix_reg[2] <= blue;
            // an overlong frame ends at the last slot
            last_reg   <= last_pixel || (pos_reg == POS_LAST);
        end

        if ((state_reg == ST_BUDGET) && den_zero)
            budget_reg <= BUDGET_MAX;
        if ((state_reg == ST_BUDGET_WAIT) && div_done)
            budget_reg <= div_quot[BUDGET_W-1:0];

        if ((state_reg == ST_BUDGET) && (frame_bright_reg == '0))
            thr_reg <= '0;
        if ((state_reg == ST_THR_WAIT) && div_done)
            thr_reg <= div_quot[THR_W-1:0];

        if (state_reg == ST_SCALE)
            scaled_reg[ch_idx_reg] <= scale_out;

        if (state_reg == ST_LIMIT)
        begin
            for (int i = 0; i < NUM_CH; i++)
                res_pix_reg[i] <= (lim_now && nonblack) ? CH_W'(1) : scaled_reg[i];
            res_limited_reg <= lim_now;
            ma_reg          <= '0;
        end

        // ma = (((used*1000) >> 8) * ma_per_led + 500) / 3000, saturated;
        // the /3000 is a drop of 3 bits and a reciprocal multiply by 1/375
        if (state_reg == ST_MUL_A)
            mul_a_reg <= {10'b0, used_sum_reg} * 30'd1000;
        if (state_reg == ST_MUL_B)
            mul_b_reg <= {16'b0, mul_a_reg[29:8]} * {22'b0, ma_per_led_reg} + DIV_W'(500);
        if (state_reg == ST_MA_DIV)
            recip_reg <= {26'b0, mul_b_reg[27:3]} * {25'b0, MA_RECIP};
        if (state_reg == ST_MA_WAIT)
            ma_reg <= (mul_b_reg >= MA_SAT_AT) ? '1 : recip_reg[MA_SHIFT +: MA_W];

        if ((state_reg == ST_PUT) && out_free)
        begin
            out_red_reg     <= res_pix_reg[0];
            out_green_reg   <= res_pix_reg[1];
            out_blue_reg    <= res_pix_reg[2];
            out_limited_reg <= res_limited_reg;
            out_end_reg     <= last_reg;
            out_ma_reg      <= ma_reg;
            out_count_reg   <= last_reg ? lim_count_reg : '0;
        end
    end

    // ---------------- result transfer ----------------
    assign out_valid   = out_valid_reg;
    assign out_red     = out_red_reg;
    assign out_green   = out_green_reg;
    assign out_blue    = out_blue_reg;
    assign was_limited = out_limited_reg;
    assign frame_end   = out_end_reg;
    assign ma_used     = out_ma_reg;
    assign num_limited = out_count_reg;

endmodule
